>>> rtl/arl_pkg.sv
// ----------------------------------------------------------------------------
// arl_pkg
// Shared types, sizes, codes and word helpers for the ordered array list
// engine.
// ----------------------------------------------------------------------------
package arl_pkg;

   // list sizing
   localparam int DEPTH     = 8;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   // command codes
   localparam logic [3:0] CMD_INS_AT    = 4'd0;
   localparam logic [3:0] CMD_INS_FIRST = 4'd1;
   localparam logic [3:0] CMD_INS_LAST  = 4'd2;
   localparam logic [3:0] CMD_DEL_AT    = 4'd3;
   localparam logic [3:0] CMD_DEL_KEY   = 4'd4;
   localparam logic [3:0] CMD_REPLACE   = 4'd5;
   localparam logic [3:0] CMD_READ      = 4'd6;
   localparam logic [3:0] CMD_SEARCH    = 4'd7;
   localparam logic [3:0] CMD_CLEAR     = 4'd8;

   // status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_NOKEY  = 2'd3;

   // storage port request from the sequencer
   typedef struct packed {
      logic                 we;
      logic [IDX_BITS-1:0]  waddr;
      logic [WORD_BITS-1:0] wdata;
      logic                 re;
      logic [IDX_BITS-1:0]  raddr;
   } ram_req_type;

   // finished result of one request
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
      logic               found;
      logic [8:0]         length;
   } result_type;

   // 32-bit request value to stored word
   function automatic logic [WORD_BITS-1:0] word_in(input logic signed [31:0] v);
      logic [63:0] t;
      t = 64'(v);
      return t[WORD_BITS-1:0];
   endfunction

   // stored word to 32-bit result, sign-extended
   function automatic logic signed [31:0] word_out(input logic [WORD_BITS-1:0] w);
      logic [63:0] t;
      t = 64'(signed'(w));
      return signed'(t[31:0]);
   endfunction

endpackage

>>> rtl/ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Bounded ordered list of signed words with insert, delete, replace, read,
// search and clear commands; one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_command, req_position, req_value) is taken at a clock edge
//   with req_valid high and req_stall low. Exactly one response follows on
//   rsp_status, rsp_data_out, rsp_found and rsp_length, held while rsp_valid
//   is high and rsp_stall is high.
//   One request is worked on at a time; req_stall stays high from the cycle
//   after acceptance until the sequencer returns to idle.
//   Rejected requests, replace, clear and unused codes go straight to the
//   response; read passes through one read state; inserts move entries up
//   one by one; search compares entries one by one; delete compares, then
//   moves later entries down one by one. Walks go through the single
//   storage read port.
//   A finished response waits in the sequencer while rsp_stall holds the
//   previous one; no new request is accepted while a response waits there.
//   Reset (synchronous, active high) empties the list and drops any pending
//   response; storage contents are not cleared, only the fill count.
// ----------------------------------------------------------------------------
module ordered_array_list_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_command,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data_out,
   output logic               rsp_found,
   output logic [8:0]         rsp_length
);
   import arl_pkg::*;

   ram_req_type          ram_req;
   result_type           result;
   logic [WORD_BITS-1:0] rd_data;
   logic                 busy;
   logic                 done;
   logic                 start;
   logic                 slot_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff,       rsp_in;

   // request handshake
   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   arl_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (req_command),
      .pos       (req_position),
      .value     (req_value),
      .slot_free (slot_free),
      .rd_data   (rd_data),
      .ram_req   (ram_req),
      .busy      (busy),
      .done      (done),
      .result    (result)
   );

   arl_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (rd_data)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_ff.status;
   assign rsp_data_out = rsp_ff.data;
   assign rsp_found    = rsp_ff.found;
   assign rsp_length   = rsp_ff.length;

endmodule

>>> rtl/arl_ram.sv
// ----------------------------------------------------------------------------
// arl_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module arl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/arl_seq.sv
// ----------------------------------------------------------------------------
// arl_seq
// Command sequencer: checks each request, then walks the list one entry per
// cycle through the storage port, with one shared key comparator.
// ----------------------------------------------------------------------------
module arl_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [3:0]                    cmd,
   input  logic [7:0]                    pos,
   input  logic signed [31:0]            value,
   input  logic                          slot_free,
   input  logic [arl_pkg::WORD_BITS-1:0] rd_data,
   output arl_pkg::ram_req_type          ram_req,
   output logic                          busy,
   output logic                          done,
   output arl_pkg::result_type           result
);
   import arl_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UP   = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_DN   = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]           state_ff,  state_in;
   logic [IDX_BITS-1:0]  idx_ff,    idx_in;
   logic [IDX_BITS-1:0]  pos_ff,    pos_in;
   logic                 pend_ff,   pend_in;
   logic                 force_ff,  force_in;
   logic [3:0]           cmd_ff,    cmd_in;
   logic [WORD_BITS-1:0] item_ff,   item_in;
   logic [CNT_BITS-1:0]  count_ff,  count_in;
   logic [1:0]           status_ff, status_in;
   logic signed [31:0]   data_ff,   data_in;
   logic                 found_ff,  found_in;

   // sequencer next state and storage requests
   always_comb begin
      logic [8:0]          pos_w;
      logic [8:0]          cnt_w;
      logic                full;
      logic                pos_bad;
      logic [IDX_BITS-1:0] ipos;
      logic [CNT_BITS-1:0] nxt1;
      logic [CNT_BITS-1:0] nxt2;
      logic                match;

      state_in  = state_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      force_in  = force_ff;
      cmd_in    = cmd_ff;
      item_in   = item_ff;
      count_in  = count_ff;
      status_in = status_ff;
      data_in   = data_ff;
      found_in  = found_ff;
      ram_req   = '0;
      done      = 1'b0;

      pos_w   = {1'b0, pos};
      cnt_w   = 9'(count_ff);
      full    = (count_ff >= CNT_BITS'(DEPTH));
      pos_bad = (pos_w >= cnt_w);
      ipos    = IDX_BITS'(pos);
      nxt1    = CNT_BITS'(idx_ff) + 1'b1;
      nxt2    = CNT_BITS'(idx_ff) + 2'd2;
      match   = force_ff || (rd_data == item_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = cmd;
               item_in   = word_in(value);
               status_in = ST_DONE;
               data_in   = '0;
               found_in  = 1'b0;
               force_in  = 1'b0;
               pend_in   = 1'b0;
               state_in  = S_DONE;
               unique case (cmd) inside
                  CMD_INS_AT, CMD_INS_FIRST, CMD_INS_LAST: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else if (cmd == CMD_INS_AT && pos_w > cnt_w) begin
                        status_in = ST_BADPOS;
                     end else begin
                        if (cmd == CMD_INS_FIRST) begin
                           ipos = '0;
                        end else if (cmd == CMD_INS_LAST) begin
                           ipos = IDX_BITS'(count_ff);
                        end
                        pos_in   = ipos;
                        idx_in   = IDX_BITS'(count_ff);
                        state_in = S_UP;
                        // fetch the last entry to start the upward shift
                        if (count_ff > CNT_BITS'(ipos)) begin
                           ram_req.re    = 1'b1;
                           ram_req.raddr = IDX_BITS'(count_ff - 1'b1);
                           pend_in       = 1'b1;
                        end
                     end
                  end
                  CMD_DEL_AT: begin
                     if (pos_bad) begin
                        status_in = ST_BADPOS;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = ipos;
                        idx_in        = ipos;
                        force_in      = 1'b1;
                        state_in      = S_SCAN;
                     end
                  end
                  CMD_DEL_KEY, CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = (cmd == CMD_DEL_KEY) ? ST_NOKEY : ST_DONE;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = '0;
                        idx_in        = '0;
                        state_in      = S_SCAN;
                     end
                  end
                  CMD_REPLACE: begin
                     if (pos_bad) begin
                        status_in = ST_BADPOS;
                     end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = ipos;
                        ram_req.wdata = word_in(value);
                     end
                  end
                  CMD_READ: begin
                     if (pos_bad) begin
                        status_in = ST_BADPOS;
                     end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = ipos;
                        state_in      = S_RD;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // read data back from storage
         S_RD: begin
            data_in  = word_out(rd_data);
            state_in = S_DONE;
         end

         // shift entries up by one, then drop the new item in the gap
         S_UP: begin
            if (pend_ff) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = idx_ff;
               ram_req.wdata = rd_data;
               idx_in        = idx_ff - 1'b1;
               if ((idx_ff - 1'b1) > pos_ff) begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = idx_ff - 2'd2;
               end else begin
                  pend_in = 1'b0;
               end
            end else begin
               ram_req.we    = 1'b1;
               ram_req.waddr = pos_ff;
               ram_req.wdata = item_ff;
               count_in      = count_ff + 1'b1;
               state_in      = S_DONE;
            end
         end

         // compare one entry per cycle while the next one is fetched
         S_SCAN: begin
            if (match) begin
               if (cmd_ff == CMD_SEARCH) begin
                  found_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  data_in  = word_out(rd_data);
                  found_in = !force_ff;
                  if (nxt1 < count_ff) begin
                     ram_req.re    = 1'b1;
                     ram_req.raddr = IDX_BITS'(nxt1);
                     state_in      = S_DN;
                  end else begin
                     count_in = count_ff - 1'b1;
                     state_in = S_DONE;
                  end
               end
            end else if (nxt1 < count_ff) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = IDX_BITS'(nxt1);
               idx_in        = IDX_BITS'(nxt1);
            end else begin
               status_in = (cmd_ff == CMD_DEL_KEY) ? ST_NOKEY : ST_DONE;
               state_in  = S_DONE;
            end
         end

         // close the gap: shift later entries down by one
         S_DN: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = idx_ff;
            ram_req.wdata = rd_data;
            if (nxt2 < count_ff) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = IDX_BITS'(nxt2);
               idx_in        = IDX_BITS'(nxt1);
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         // hand the result over once the response register is free
         S_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      pend_ff   <= pend_in;
      force_ff  <= force_in;
      cmd_ff    <= cmd_in;
      item_ff   <= item_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      found_ff  <= found_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign result.status = status_ff;
   assign result.data   = data_ff;
   assign result.found  = found_ff;
   assign result.length = 9'(count_ff);

endmodule

>>> rtl/arl_checker.sv
// ----------------------------------------------------------------------------
// arl_checker
// Port-level checks for the ordered array list engine, bound to the top.
// ----------------------------------------------------------------------------
module arl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_data_out,
   input logic               rsp_found,
   input logic [8:0]         rsp_length
);
   import arl_pkg::*;

   // one request at a time: acceptance closes the input side
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one in progress");

   // reported length never exceeds the list capacity
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length <= 9'(DEPTH)))
      else $error("response length above capacity");

   // a full rejection only happens with the list at capacity
   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_length == 9'(DEPTH)))
      else $error("list full reported below capacity");

   // a match is always a successful request
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_DONE))
      else $error("found flag with error status");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_data_out) && $stable(rsp_found) && $stable(rsp_length)))
      else $error("stalled response changed");

endmodule

bind ordered_array_list_engine arl_checker u_arl_checker (.*);

>>> tb/tb_ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// tb_ordered_array_list_engine
// Self-checking bench for the ordered array list engine. A shadow list inside
// a small scoreboard class predicts status, data, found flag and length for
// every accepted request. Responses are checked in order. Stimulus is a
// directed opening over empty, full and bad-position cases, then random
// commands. The sender works in bursts and the receiver stalls on patterns,
// including long hold-offs that back the engine up.
// ----------------------------------------------------------------------------
module tb_ordered_array_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import arl_pkg::*;

   localparam int         RANDOM_REQUESTS = 1550;
   localparam int         CYCLE_LIMIT     = 600000;
   localparam int         DRAIN_CYCLES    = 4 * DEPTH + 20;
   localparam int         HOLD_CYCLES     = 300;
   localparam logic [3:0] CMD_UNUSED_LO   = CMD_CLEAR + 4'd1;
   localparam logic [3:0] CMD_UNUSED_HI   = 4'hF;

   // shadow of the list plus the queue of predicted responses
   class list_scoreboard;
      logic [WORD_BITS-1:0] entries [DEPTH];
      int                   count;
      int                   errors;
      result_type           pending_results [$];

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // stored word back to a sign-extended 32-bit value
      function logic signed [31:0] read_word(int idx);
         logic signed [WORD_BITS-1:0] w;
         logic signed [63:0]          t;
         w = entries[idx];
         t = w;
         return t[31:0];
      endfunction

      function void open_slot(int pos, logic [WORD_BITS-1:0] item);
         for (int i = count; i > pos; i--) entries[i] = entries[i-1];
         entries[pos] = item;
         count++;
      endfunction

      function void remove_slot(int pos);
         for (int i = pos; i + 1 < count; i++) entries[i] = entries[i+1];
         count--;
      endfunction

      // work out the response of one accepted request
      function void note_request(logic [3:0] cmd, logic [7:0] pos,
                                 logic signed [31:0] val);
         result_type           r;
         logic signed [63:0]   wide;
         logic [WORD_BITS-1:0] item;
         int                   hit;
         r    = '0;
         wide = val;
         item = wide[WORD_BITS-1:0];
         hit  = -1;
         case (cmd)
            CMD_INS_AT: begin
               if (count >= DEPTH) r.status = ST_FULL;
               else if (int'(pos) > count) r.status = ST_BADPOS;
               else open_slot(pos, item);
            end
            CMD_INS_FIRST: begin
               if (count >= DEPTH) r.status = ST_FULL;
               else open_slot(0, item);
            end
            CMD_INS_LAST: begin
               if (count >= DEPTH) r.status = ST_FULL;
               else open_slot(count, item);
            end
            CMD_DEL_AT: begin
               if (int'(pos) >= count) r.status = ST_BADPOS;
               else begin
                  r.data = read_word(pos);
                  remove_slot(pos);
               end
            end
            CMD_DEL_KEY: begin
               r.status = ST_NOKEY;
               for (int i = 0; i < count; i++)
                  if (hit < 0 && entries[i] == item) hit = i;
               if (hit >= 0) begin
                  r.data   = read_word(hit);
                  r.found  = 1'b1;
                  r.status = ST_DONE;
                  remove_slot(hit);
               end
            end
            CMD_REPLACE: begin
               if (int'(pos) >= count) r.status = ST_BADPOS;
               else entries[pos] = item;
            end
            CMD_READ: begin
               if (int'(pos) >= count) r.status = ST_BADPOS;
               else r.data = read_word(pos);
            end
            CMD_SEARCH: begin
               for (int i = 0; i < count; i++)
                  if (entries[i] == item) r.found = 1'b1;
            end
            CMD_CLEAR: count = 0;
            default: ;
         endcase
         r.length = 9'(count);
         pending_results.push_back(r);
      endfunction

      // compare one accepted response with the oldest prediction
      function void check_response(logic [1:0] status, logic signed [31:0] data,
                                   logic found, logic [8:0] length);
         result_type e;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = pending_results.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
         end
         if (data !== e.data) begin
            $error("data_out: expected %0d, got %0d", e.data, data);
            errors++;
         end
         if (found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, found);
            errors++;
         end
         if (length !== e.length) begin
            $error("length: expected %0d, got %0d", e.length, length);
            errors++;
         end
      endfunction
   endclass

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               req_valid    = 1'b0;
   logic               req_stall;
   logic [3:0]         req_command  = CMD_CLEAR;
   logic [7:0]         req_position = '0;
   logic signed [31:0] req_value    = '0;
   logic               rsp_valid;
   logic               rsp_stall    = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data_out;
   logic               rsp_found;
   logic [8:0]         rsp_length;

   list_scoreboard shadow_list = new();
   int             burst_left  = 1;
   int             cycles      = 0;

   logic signed [31:0] value_pool [8] = '{0, -1, 1, 32'h7FFF_FFFF, 32'h8000_0000,
                                          5, -100, 32'h55AA_55AA};

   ordered_array_list_engine dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_found    (rsp_found),
      .rsp_length   (rsp_length)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow_list.check_response(rsp_status, rsp_data_out, rsp_found, rsp_length);
   end

   // receiver stall patterns with a long hold-off every twenty segments
   initial begin
      int seg;
      int mode;
      int span;
      seg = 0;
      wait (!reset);
      forever begin
         seg++;
         if (seg % 20 == 4) begin
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span) begin
               @(posedge clock);
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ~rsp_stall;
               endcase
            end
         end
      end
   end

   // offer one request and wait for it to be taken, then maybe pause
   task automatic send_request(input logic [3:0] cmd, input logic [7:0] pos,
                               input logic signed [31:0] val);
      int gap;
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall);
      shadow_list.note_request(cmd, pos, val);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 16);
      end
   endtask

   function automatic logic [3:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 16) return CMD_INS_AT;
      if (r < 26) return CMD_INS_FIRST;
      if (r < 40) return CMD_INS_LAST;
      if (r < 52) return CMD_DEL_AT;
      if (r < 62) return CMD_DEL_KEY;
      if (r < 71) return CMD_REPLACE;
      if (r < 81) return CMD_READ;
      if (r < 91) return CMD_SEARCH;
      if (r < 94) return CMD_CLEAR;
      return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
   endfunction

   function automatic logic signed [31:0] pick_value(logic [3:0] cmd);
      // keys mostly hit an entry that is currently in the list
      if ((cmd == CMD_DEL_KEY || cmd == CMD_SEARCH) && shadow_list.count > 0 &&
          $urandom_range(0, 9) < 6)
         return shadow_list.read_word($urandom_range(0, shadow_list.count - 1));
      if ($urandom_range(0, 9) < 4) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // main sequence
   initial begin
      logic [3:0] cmd;
      logic [7:0] pos;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list errors
      send_request(CMD_CLEAR,     8'd0,   32'sd0);
      send_request(CMD_READ,      8'd0,   32'sd0);
      send_request(CMD_DEL_AT,    8'd0,   32'sd0);
      send_request(CMD_DEL_KEY,   8'd0,   32'sd0);
      send_request(CMD_SEARCH,    8'd0,   32'sd0);
      send_request(CMD_INS_AT,    8'd1,   32'sd7);
      // build, read back, replace, search
      send_request(CMD_INS_FIRST, 8'd0,   32'h8000_0000);
      send_request(CMD_INS_LAST,  8'd0,   32'h7FFF_FFFF);
      send_request(CMD_INS_AT,    8'd1,   -32'sd1);
      send_request(CMD_INS_AT,    8'hFF,  32'sd3);
      send_request(CMD_READ,      8'd2,   32'sd0);
      send_request(CMD_REPLACE,   8'd1,   32'sd0);
      send_request(CMD_REPLACE,   8'd3,   32'sd9);
      send_request(CMD_SEARCH,    8'd0,   32'h7FFF_FFFF);
      send_request(CMD_DEL_KEY,   8'd0,   -32'sd1);
      send_request(CMD_INS_AT,    8'd3,   32'sd12345);
      // fill the list up to capacity, then delete from it
      repeat (DEPTH - 4) send_request(CMD_INS_LAST, 8'd0, $urandom);
      send_request(CMD_INS_AT,    8'd200, 32'sd1);
      send_request(CMD_INS_FIRST, 8'd0,   32'sd2);
      send_request(CMD_INS_LAST,  8'd0,   32'sd3);
      send_request(CMD_DEL_AT,    8'(DEPTH - 1), 32'sd0);
      send_request(CMD_DEL_KEY,   8'd0,   32'h8000_0000);
      send_request(CMD_UNUSED_HI, 8'd0,   32'sd0);
      send_request(CMD_CLEAR,     8'd0,   32'sd0);

      // random commands, positions mostly in range
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         cmd = pick_command();
         if ($urandom_range(0, 4) == 0) pos = 8'($urandom_range(0, 255));
         else pos = 8'($urandom_range(0, shadow_list.count));
         send_request(cmd, pos, pick_value(cmd));
      end
      req_valid <= 1'b0;

      // drain and settle
      while (shadow_list.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow_list.errors == 0 && shadow_list.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
